FILE: rtl/bplru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bplru_pkg
// Shared types, sizes and codes of the pinned LRU buffer pool.
// ----------------------------------------------------------------------------
package bplru_pkg;

    localparam int SLOTS      = 8;
    localparam int TAG_BITS   = 24;
    localparam int PIN_BITS   = 8;
    localparam int STAMP_BITS = 32;
    localparam int CHUNK_BITS = 24;
    localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [PIN_BITS-1:0]   PIN_MAX   = {PIN_BITS{1'b1}};
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};

    localparam logic MODE_ACQ = 1'b0;
    localparam logic MODE_REL = 1'b1;

    localparam logic [2:0] STAT_HIT     = 3'd0;
    localparam logic [2:0] STAT_ALLOC   = 3'd1;
    localparam logic [2:0] STAT_NONE    = 3'd2;
    localparam logic [2:0] STAT_REL     = 3'd3;
    localparam logic [2:0] STAT_NOMATCH = 3'd4;
    localparam logic [2:0] STAT_UNDER   = 3'd5;

    typedef struct packed {
        logic [TAG_BITS-1:0]   tag;
        logic [PIN_BITS-1:0]   pins;
        logic [STAMP_BITS-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] slot;
        logic [7:0] pin_count;
    } t_res;

    function automatic logic [TAG_BITS-1:0] chunk_to_tag(input logic [CHUNK_BITS-1:0] c);
        logic [TAG_BITS+CHUNK_BITS-1:0] w;
        w = {{TAG_BITS{1'b0}}, c};
        return w[TAG_BITS-1:0];
    endfunction

    function automatic logic [7:0] pins_to_out(input logic [PIN_BITS-1:0] p);
        logic [PIN_BITS+7:0] w;
        w = {8'd0, p};
        return w[7:0];
    endfunction

    function automatic logic [2:0] idx_to_out(input logic [IDX_W-1:0] i);
        logic [IDX_W+2:0] w;
        w = {3'd0, i};
        return w[2:0];
    endfunction

endpackage

FILE: rtl/bplru_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bplru_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bplru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: rtl/bplru_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bplru_ctrl
// Sequencer that scans the slot memory, picks the hit or the LRU victim of an
// acquire and writes it back; a release unpins matching slots during the scan.
// ----------------------------------------------------------------------------
module bplru_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_mode,
    input  logic [bplru_pkg::TAG_BITS-1:0]      i_tag,
    input  logic                                i_stall,
    output logic                                o_res_valid,
    output bplru_pkg::t_res                     o_res,
    output logic                                o_ram_re,
    output logic [bplru_pkg::IDX_W-1:0]         o_ram_raddr,
    input  bplru_pkg::t_entry                   i_ram_rdata,
    output logic                                o_ram_we,
    output logic [bplru_pkg::IDX_W-1:0]         o_ram_waddr,
    output bplru_pkg::t_entry                   o_ram_wdata
);
    import bplru_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

    t_state                r_state, n_state;
    logic [SLOTS-1:0]      r_valid, n_valid;
    logic [STAMP_BITS-1:0] r_clock, n_clock;
    logic                  r_mode, n_mode;
    logic [TAG_BITS-1:0]   r_tag, n_tag;
    logic [IDX_W-1:0]      r_ptr, n_ptr;
    logic                  r_hit, n_hit;
    logic [IDX_W-1:0]      r_hit_idx, n_hit_idx;
    logic [PIN_BITS-1:0]   r_hit_pins, n_hit_pins;
    logic                  r_pick_ok, n_pick_ok;
    logic [IDX_W-1:0]      r_pick_idx, n_pick_idx;
    logic [STAMP_BITS-1:0] r_pick_stamp, n_pick_stamp;
    logic                  r_under, n_under;

    t_entry                entry;
    logic                  match;
    logic [STAMP_BITS-1:0] stamp_next;
    logic [PIN_BITS-1:0]   pins_inc;

    // An empty slot reads as all zeros, whatever the memory holds.
    assign entry      = r_valid[r_ptr] ? i_ram_rdata : '0;
    assign match      = r_valid[r_ptr] && (entry.tag == r_tag);
    assign stamp_next = (r_clock == STAMP_MAX) ? r_clock : r_clock + STAMP_BITS'(1);
    assign pins_inc   = (r_hit_pins == PIN_MAX) ? r_hit_pins : r_hit_pins + PIN_BITS'(1);

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_clock      = r_clock;
        n_mode       = r_mode;
        n_tag        = r_tag;
        n_ptr        = r_ptr;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_hit_pins   = r_hit_pins;
        n_pick_ok    = r_pick_ok;
        n_pick_idx   = r_pick_idx;
        n_pick_stamp = r_pick_stamp;
        n_under      = r_under;
        o_in_ready   = 1'b0;
        o_res_valid  = 1'b0;
        o_res        = '0;
        o_ram_re     = 1'b0;
        o_ram_raddr  = '0;
        o_ram_we     = 1'b0;
        o_ram_waddr  = '0;
        o_ram_wdata  = '0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_mode    = i_mode;
                    n_tag     = i_tag;
                    n_ptr     = '0;
                    n_hit     = 1'b0;
                    n_pick_ok = 1'b0;
                    n_under   = 1'b0;
                    o_ram_re  = 1'b1;
                    n_state   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_mode == MODE_ACQ) begin
                    if (match && !r_hit) begin
                        n_hit      = 1'b1;
                        n_hit_idx  = r_ptr;
                        n_hit_pins = entry.pins;
                    end
                    if (entry.pins == '0 && (!r_pick_ok || entry.stamp < r_pick_stamp)) begin
                        n_pick_ok    = 1'b1;
                        n_pick_idx   = r_ptr;
                        n_pick_stamp = entry.stamp;
                    end
                end else if (match) begin
                    // Each matching slot is unpinned in place as the scan passes it.
                    if (entry.pins == '0) begin
                        n_under = 1'b1;
                    end else begin
                        o_ram_we         = 1'b1;
                        o_ram_waddr      = r_ptr;
                        o_ram_wdata      = entry;
                        o_ram_wdata.pins = entry.pins - PIN_BITS'(1);
                    end
                    if (!r_hit) begin
                        n_hit      = 1'b1;
                        n_hit_idx  = r_ptr;
                        n_hit_pins = (entry.pins == '0) ? '0 : entry.pins - PIN_BITS'(1);
                    end
                end
                if (r_ptr != LAST) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = r_ptr + IDX_W'(1);
                    n_ptr       = r_ptr + IDX_W'(1);
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!i_stall) begin
                    o_res_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (r_mode == MODE_ACQ) begin
                        if (r_hit) begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = r_hit_idx;
                            o_ram_wdata = '{tag: r_tag, pins: pins_inc, stamp: stamp_next};
                            n_clock     = stamp_next;
                            o_res       = '{status: STAT_HIT, slot: idx_to_out(r_hit_idx),
                                            pin_count: pins_to_out(pins_inc)};
                        end else if (r_pick_ok) begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = r_pick_idx;
                            o_ram_wdata = '{tag: r_tag, pins: PIN_BITS'(1), stamp: stamp_next};
                            n_clock     = stamp_next;
                            n_valid[r_pick_idx] = 1'b1;
                            o_res       = '{status: STAT_ALLOC, slot: idx_to_out(r_pick_idx),
                                            pin_count: pins_to_out(PIN_BITS'(1))};
                        end else begin
                            o_res = '{status: STAT_NONE, slot: 3'd0, pin_count: 8'd0};
                        end
                    end else begin
                        if (r_hit) begin
                            o_res = '{status: r_under ? STAT_UNDER : STAT_REL,
                                      slot: idx_to_out(r_hit_idx),
                                      pin_count: pins_to_out(r_hit_pins)};
                        end else begin
                            o_res = '{status: STAT_NOMATCH, slot: 3'd0, pin_count: 8'd0};
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_clock <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_clock <= n_clock;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_tag        <= n_tag;
        r_ptr        <= n_ptr;
        r_hit        <= n_hit;
        r_hit_idx    <= n_hit_idx;
        r_hit_pins   <= n_hit_pins;
        r_pick_ok    <= n_pick_ok;
        r_pick_idx   <= n_pick_idx;
        r_pick_stamp <= n_pick_stamp;
        r_under      <= n_under;
    end

endmodule

FILE: rtl/pinned_buffer_pool_lru_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinned_buffer_pool_lru_top
// Pool of chunk buffer slots with pin counts and least-recently-used refill.
// ----------------------------------------------------------------------------
// An acquire word (tuser 0) looks up the chunk in tdata: a hit pins the slot,
// a miss takes the oldest unpinned slot and reports that it needs loading, and
// a full pool reports that no buffer is free. A release word (tuser 1) unpins
// every slot holding that chunk. Each word yields exactly one result word. An
// item is accepted, then each slot in turn is read from the slot memory
// through its single read port, and last the chosen slot is written back and
// the result handed to the output register, unless that register is stalled. A
// new word is taken while the previous result is still waiting on the output side.
// ----------------------------------------------------------------------------
module pinned_buffer_pool_lru_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [23:0] chunk_index
    input  logic [0:0]  s_axis_tuser,  // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [2:0] slot, [10:3] pin_count, rest zero
    output logic [2:0]  m_axis_tuser   // [2:0] status
);
    import bplru_pkg::*;

    logic                 res_valid;
    t_res                 res;
    logic                 stall;
    logic                 ram_re, ram_we;
    logic [IDX_W-1:0]     ram_raddr, ram_waddr;
    t_entry               ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic                 r_m_valid;
    t_res                 r_m_res;

    assign stall = r_m_valid && !m_axis_tready;

    bplru_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bplru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_mode      (s_axis_tuser[0]),
        .i_tag       (chunk_to_tag(s_axis_tdata)),
        .i_stall     (stall),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_m_res <= res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {5'd0, r_m_res.pin_count, r_m_res.slot};
    assign m_axis_tuser  = r_m_res.status;

`ifndef SYNTH
    // The sequencer must never overwrite a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !stall)
        else $error("result produced while output register is stalled");

    // Once a word is taken the sequencer is busy scanning on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted again straight after an accept");

    // A result always carries one of the defined status codes.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (res.status == STAT_HIT || res.status == STAT_ALLOC ||
                       res.status == STAT_NONE || res.status == STAT_REL ||
                       res.status == STAT_NOMATCH || res.status == STAT_UNDER))
        else $error("undefined status code");

    // While the sequencer is idle, a read is issued only for an offered word.
    a_read_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tready && ram_re) |-> s_axis_tvalid)
        else $error("slot memory read without an accepted word");
`endif

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pinned LRU buffer pool.
// ----------------------------------------------------------------------------
// A short scripted sequence walks the pool through allocation, hits, release,
// underflow, a full pool and the oldest-slot choice. A long run of acquires on
// one chunk drives its pin count into saturation and back down through
// underflow. Random traffic follows, drawn mostly from a small set of busy
// chunks so that hits, refills and full pools keep occurring. Every accepted
// word is run through a behavioural copy of the pool, and each result word is
// checked against the oldest outstanding prediction. Both stream sides pause
// at random, with stretches of full throughput.
// ----------------------------------------------------------------------------
module tb;
    import bplru_pkg::*;

    localparam int ITEM_CYCLES = SLOTS + 2;
    localparam int HOT_CHUNKS  = 12;
    localparam int BLOCKS      = 13;
    localparam int BLOCK_ITEMS = 100;
    localparam int SAT_RUN     = 260;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // [23:0] chunk_index
    logic [0:0]  s_axis_tuser  = '0;   // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [2:0] slot, [10:3] pin_count
    logic [2:0]  m_axis_tuser;         // [2:0] status

    pinned_buffer_pool_lru_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #6_000_000;
        $display("pinned_buffer_pool_lru_top: mismatch");
        $finish;
    end

    // Behavioural copy of the pool.
    logic [TAG_BITS-1:0]   pool_tag   [SLOTS];
    logic                  pool_valid [SLOTS];
    logic [PIN_BITS-1:0]   pool_pins  [SLOTS];
    logic [STAMP_BITS-1:0] pool_stamp [SLOTS];
    logic [STAMP_BITS-1:0] pool_clock;

    t_res due_results [$];
    int   faults = 0;
    bit   steady = 1'b0;

    function automatic logic [STAMP_BITS-1:0] stamp_tick();
        if (pool_clock != STAMP_MAX) pool_clock++;
        return pool_clock;
    endfunction

    function automatic t_res pool_access(input logic mode, input logic [CHUNK_BITS-1:0] chunk);
        logic [TAG_BITS-1:0] tag;
        int pick;
        int first;
        bit under;
        t_res r;
        tag   = chunk[TAG_BITS-1:0];
        pick  = -1;
        first = -1;
        under = 1'b0;
        r     = '0;
        if (mode == MODE_ACQ) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (pool_valid[i] && pool_tag[i] == tag) begin
                    if (pool_pins[i] != PIN_MAX) pool_pins[i]++;
                    pool_stamp[i] = stamp_tick();
                    r.status    = STAT_HIT;
                    r.slot      = 3'(i);
                    r.pin_count = 8'(pool_pins[i]);
                    return r;
                end
            end
            // Oldest unpinned slot; the strict compare keeps the lowest index on a tie.
            for (int i = 0; i < SLOTS; i++) begin
                if (pool_pins[i] == '0 && (pick < 0 || pool_stamp[pick] > pool_stamp[i]))
                    pick = i;
            end
            if (pick < 0) begin
                r.status = STAT_NONE;
                return r;
            end
            pool_tag[pick]   = tag;
            pool_valid[pick] = 1'b1;
            pool_pins[pick]  = PIN_BITS'(1);
            pool_stamp[pick] = stamp_tick();
            r.status    = STAT_ALLOC;
            r.slot      = 3'(pick);
            r.pin_count = 8'(pool_pins[pick]);
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                if (pool_valid[i] && pool_tag[i] == tag) begin
                    if (first < 0) first = i;
                    if (pool_pins[i] == '0) under = 1'b1;
                    else pool_pins[i]--;
                end
            end
            if (first < 0) begin
                r.status = STAT_NOMATCH;
                return r;
            end
            r.status    = under ? STAT_UNDER : STAT_REL;
            r.slot      = 3'(first);
            r.pin_count = 8'(pool_pins[first]);
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (steady || p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic feed(input logic mode, input logic [23:0] chunk,
                        input bit typed, input t_res typed_res);
        int gap;
        t_res r;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= chunk;
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        r = pool_access(mode, chunk);
        due_results.push_back(typed ? typed_res : r);
        @(negedge i_clk);
    endtask

    // Holds the sender back until every outstanding result word has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    typedef struct {
        logic        mode;
        logic [23:0] chunk;
        bit          typed;
        t_res        res;
    } t_row;

    // Rows with typed results follow the pool state by hand; the others are predicted.
    t_row script [0:21] = '{
        '{MODE_REL, 24'h000000, 1'b1, '{STAT_NOMATCH, 3'd0, 8'd0}},
        '{MODE_ACQ, 24'h000000, 1'b1, '{STAT_ALLOC,   3'd0, 8'd1}},
        '{MODE_ACQ, 24'hFFFFFF, 1'b1, '{STAT_ALLOC,   3'd1, 8'd1}},
        '{MODE_ACQ, 24'h000000, 1'b1, '{STAT_HIT,     3'd0, 8'd2}},
        '{MODE_REL, 24'h000000, 1'b1, '{STAT_REL,     3'd0, 8'd1}},
        '{MODE_REL, 24'h000000, 1'b1, '{STAT_REL,     3'd0, 8'd0}},
        '{MODE_REL, 24'h000000, 1'b1, '{STAT_UNDER,   3'd0, 8'd0}},
        '{MODE_REL, 24'hFFFFFF, 1'b1, '{STAT_REL,     3'd1, 8'd0}},
        '{MODE_ACQ, 24'hFFFFFF, 1'b1, '{STAT_HIT,     3'd1, 8'd1}},
        '{MODE_ACQ, 24'h555555, 1'b1, '{STAT_ALLOC,   3'd2, 8'd1}},
        '{MODE_ACQ, 24'hAAAAAA, 1'b1, '{STAT_ALLOC,   3'd3, 8'd1}},
        '{MODE_ACQ, 24'h000001, 1'b1, '{STAT_ALLOC,   3'd4, 8'd1}},
        '{MODE_ACQ, 24'h800000, 1'b1, '{STAT_ALLOC,   3'd5, 8'd1}},
        '{MODE_ACQ, 24'h123456, 1'b1, '{STAT_ALLOC,   3'd6, 8'd1}},
        '{MODE_ACQ, 24'h00FF00, 1'b1, '{STAT_ALLOC,   3'd7, 8'd1}},
        '{MODE_ACQ, 24'h0F0F0F, 1'b1, '{STAT_ALLOC,   3'd0, 8'd1}},
        '{MODE_ACQ, 24'hF0F0F0, 1'b1, '{STAT_NONE,    3'd0, 8'd0}},
        '{MODE_REL, 24'h555555, 1'b1, '{STAT_REL,     3'd2, 8'd0}},
        '{MODE_REL, 24'h0F0F0F, 1'b1, '{STAT_REL,     3'd0, 8'd0}},
        '{MODE_ACQ, 24'h000000, 1'b0, '0},
        '{MODE_ACQ, 24'h555555, 1'b0, '0},
        '{MODE_REL, 24'h7FFFFF, 1'b1, '{STAT_NOMATCH, 3'd0, 8'd0}}
    };

    initial begin : stimulus
        logic [23:0] hot [HOT_CHUNKS];
        int          acq_pct;
        logic        mode;
        logic [23:0] chunk;
        for (int i = 0; i < SLOTS; i++) begin
            pool_tag[i]   = '0;
            pool_valid[i] = 1'b0;
            pool_pins[i]  = '0;
            pool_stamp[i] = '0;
        end
        pool_clock = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[k])
            feed(script[k].mode, script[k].chunk, script[k].typed, script[k].res);
        drain();

        // Chunk zero sits in a pinned slot here: pin it past saturation, then
        // release it past zero.
        repeat (SAT_RUN) feed(MODE_ACQ, 24'h000000, 1'b0, '0);
        repeat (SAT_RUN) feed(MODE_REL, 24'h000000, 1'b0, '0);

        foreach (hot[k]) hot[k] = 24'($urandom());
        for (int b = 0; b < BLOCKS; b++) begin
            acq_pct = $urandom_range(25, 80);
            steady  = ($urandom_range(0, 3) == 0);
            hot[$urandom_range(0, HOT_CHUNKS - 1)] = 24'($urandom());
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                mode  = ($urandom_range(0, 99) < acq_pct) ? MODE_ACQ : MODE_REL;
                chunk = ($urandom_range(0, 99) < 85) ? hot[$urandom_range(0, HOT_CHUNKS - 1)]
                                                     : 24'($urandom());
                feed(mode, chunk, 1'b0, '0);
            end
            if (b % 3 == 2) drain();
        end
        steady = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4 * ITEM_CYCLES) @(posedge i_clk);
        if (faults == 0)
            $display("pinned_buffer_pool_lru_top: match");
        else
            $display("pinned_buffer_pool_lru_top: mismatch");
        $finish;
    end

    always @(negedge i_clk) begin : rx_pace
        int p;
        static int hold = 0;
        if (steady) begin
            m_axis_tready <= 1'b1;
            hold = 0;
        end else if (hold != 0) begin
            hold--;
        end else begin
            p = $urandom_range(0, 99);
            if (p < 55) begin
                m_axis_tready <= 1'b1;
                hold = $urandom_range(0, 6);
            end else if (p < 93) begin
                m_axis_tready <= 1'b0;
                hold = $urandom_range(0, 3);
            end else begin
                m_axis_tready <= 1'b0;
                hold = $urandom_range(10, 40);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_results.size() == 0) begin
                $error("result word with nothing outstanding: status %0d slot %0d pins %0d",
                       m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[10:3]);
                faults++;
            end else begin
                want = due_results.pop_front();
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    faults++;
                end
                if (m_axis_tdata[2:0] !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, m_axis_tdata[2:0]);
                    faults++;
                end
                if (m_axis_tdata[10:3] !== want.pin_count) begin
                    $error("pin_count: expected %0d, got %0d", want.pin_count,
                           m_axis_tdata[10:3]);
                    faults++;
                end
            end
        end
    end

endmodule
